// File: rtl/knn_two_feature_classifier_macros.svh
// ----------------------------------------------------------------------------
// knn_two_feature_classifier_macros.svh
// Assertion macros for the nearest neighbor classifier. The checks compile
// away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KNN_TWO_FEATURE_CLASSIFIER_MACROS_SVH
`define KNN_TWO_FEATURE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define KNN2F_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("knn2f assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KNN2F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("knn2f assertion failed");

`else

`define KNN2F_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KNN2F_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/knn2f_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn2f_pkg
// Widths, codes and defaults shared by the nearest neighbor classifier.
// ----------------------------------------------------------------------------
package knn2f_pkg;

    localparam int FEAT_W  = 64;
    localparam int LABEL_W = 52;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;

    localparam int TRAIN_DEPTH_DEF = 32;
    localparam int NEIGHBORS_DEF   = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd25;

    // Command codes carried by the input item.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [FEAT_W-1:0]  feat_t;
    typedef logic [LABEL_W-1:0] label_t;

endpackage

// File: rtl/knn_two_feature_classifier.sv
`timescale 1ns / 1ps
`include "knn_two_feature_classifier_macros.svh"
// ----------------------------------------------------------------------------
// knn_two_feature_classifier
// K nearest neighbor classifier over a table of two-feature training points.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_*) carries one item per handshake. A load item
// (command LOAD) writes coord_a, coord_b and label into table entry
// entry_index; it produces no result and leaves the controller idle. A query item
// (command QUERY) produces exactly one result item on the m_* channel:
// the majority-vote label among the NEIGHBORS entries closest to the query
// point by squared Euclidean distance (modulo 2^64, ties to the lower index).
// A query streams the table out of one synchronous memory, one entry per
// cycle, through the difference, partial-product and square stages into a
// sorted top-K list. The scan covers n, the number of entries in use
// (train_count clamped to 1..TRAIN_DEPTH); then the pipeline drains and
// the vote runs. Items are taken one at a time.
// The result sits in an output register, so the next item is accepted while
// a result waits; a second query that finishes while the receiver still
// stalls holds in its final state until the output register frees up.
// Reset clears the control state and sets train_count to 25; the table
// contents are undefined until loaded. cfg_wr_en writes train_count at once.
// ----------------------------------------------------------------------------
module knn_two_feature_classifier #(
    parameter int TRAIN_DEPTH = knn2f_pkg::TRAIN_DEPTH_DEF,
    parameter int NEIGHBORS   = knn2f_pkg::NEIGHBORS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: train_count
    input  logic                            cfg_wr_en,
    input  logic [knn2f_pkg::COUNT_W-1:0]   cfg_wr_data,
    // Input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [knn2f_pkg::INDEX_W-1:0]   s_entry_index,
    input  logic [knn2f_pkg::FEAT_W-1:0]    s_coord_a,
    input  logic [knn2f_pkg::FEAT_W-1:0]    s_coord_b,
    input  logic [knn2f_pkg::LABEL_W-1:0]   s_label,
    // Result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [knn2f_pkg::LABEL_W-1:0]   m_predicted_label
);
    import knn2f_pkg::*;

    localparam int IW    = $clog2(TRAIN_DEPTH);
    localparam int NW    = $clog2(TRAIN_DEPTH + 1);
    localparam int CMPW  = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int MEM_W = 2 * FEAT_W + LABEL_W;
    localparam int RW    = $clog2(NEIGHBORS + 1);
    localparam int SW    = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int HALF  = FEAT_W / 2;

    // Controller states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_VOTE  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] train_count_reg;

    logic               s_accept;
    logic               query_start;
    logic               load_wr;
    logic               issue;
    logic [IW-1:0]      cnt_reg;
    logic [IW-1:0]      last_idx_reg;
    logic [IW-1:0]      last_idx_next;
    logic [CMPW-1:0]    count_ext;

    feat_t              qa_reg, qb_reg;

    // Training table: {feature_a, feature_b, label} per entry.
    logic [MEM_W-1:0]   mem [TRAIN_DEPTH];
    logic [MEM_W-1:0]   rd_data_reg;

    // Distance pipeline.
    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    feat_t              da_reg, db_reg;
    label_t             lab1_reg, lab2_reg, lab3_reg;
    logic [FEAT_W-1:0]  pa_ll_reg, pb_ll_reg;
    logic [HALF-1:0]    pa_lh_reg, pb_lh_reg;
    feat_t              sqa_reg, sqb_reg;

    // Sorted list of the nearest entries so far.
    feat_t              slot_dist_reg  [NEIGHBORS];
    label_t             slot_label_reg [NEIGHBORS];
    logic [NEIGHBORS-1:0] slot_vld_reg;
    feat_t              slot_dist_next  [NEIGHBORS];
    label_t             slot_label_next [NEIGHBORS];
    logic [NEIGHBORS-1:0] slot_vld_next;
    logic [NEIGHBORS-1:0] closer;
    feat_t              new_dist;

    // Majority vote.
    logic [RW-1:0]      vote_r_reg;
    logic [RW-1:0]      votes_reg;
    label_t             cand_reg;
    logic [SW-1:0]      r_idx;
    label_t             cur_label;
    logic               vote_end;
    logic [RW-1:0]      votes_step;

    logic               m_valid_reg;
    label_t             m_label_reg;
    logic               out_free;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign query_start = s_accept && (s_command == CMD_QUERY);
    assign load_wr     = s_accept && (s_command == CMD_LOAD) &&
                         (int'(s_entry_index) < TRAIN_DEPTH);
    assign issue       = (state_reg == ST_SCAN);
    assign out_free    = !m_valid_reg || m_ready;

    // Index of the last entry in use; a zero count means one entry.
    assign count_ext = CMPW'(train_count_reg);
    always_comb begin
        if (train_count_reg == '0) begin
            last_idx_next = '0;
        end else if (count_ext > CMPW'(TRAIN_DEPTH)) begin
            last_idx_next = IW'(TRAIN_DEPTH - 1);
        end else begin
            last_idx_next = IW'(count_ext - CMPW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            train_count_reg <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            train_count_reg <= cfg_wr_data;
        end
    end

    // Loads only land while idle, and a query reads the table no earlier than
    // the cycle after its acceptance, so reads never overlap a write in flight.
    always_ff @(posedge aclk) begin
        if (load_wr) begin
            mem[IW'(s_entry_index)] <= {s_coord_a, s_coord_b, s_label};
        end
        rd_data_reg <= mem[cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (query_start) begin
            qa_reg       <= s_coord_a;
            qb_reg       <= s_coord_b;
            last_idx_reg <= last_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (query_start) begin
            cnt_reg <= '0;
        end else if (issue && (cnt_reg != last_idx_reg)) begin
            cnt_reg <= cnt_reg + IW'(1);
        end
    end

    // Stage 1: feature differences. Stage 2: partial products of the squares,
    // keeping only what survives modulo 2^64. Stage 3: the two squares.
    always_ff @(posedge aclk) begin
        da_reg    <= rd_data_reg[MEM_W-1 -: FEAT_W] - qa_reg;
        db_reg    <= rd_data_reg[LABEL_W +: FEAT_W] - qb_reg;
        lab1_reg  <= rd_data_reg[LABEL_W-1:0];

        pa_ll_reg <= da_reg[HALF-1:0] * da_reg[HALF-1:0];
        pa_lh_reg <= da_reg[HALF-1:0] * da_reg[FEAT_W-1:HALF];
        pb_ll_reg <= db_reg[HALF-1:0] * db_reg[HALF-1:0];
        pb_lh_reg <= db_reg[HALF-1:0] * db_reg[FEAT_W-1:HALF];
        lab2_reg  <= lab1_reg;

        sqa_reg   <= pa_ll_reg + {pa_lh_reg[HALF-2:0], {(HALF+1){1'b0}}};
        sqb_reg   <= pb_ll_reg + {pb_lh_reg[HALF-2:0], {(HALF+1){1'b0}}};
        lab3_reg  <= lab2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Insertion into the sorted list. Entries arrive in index order, so a
    // strict compare puts an equal distance behind the earlier entry.
    always_comb begin
        new_dist        = sqa_reg + sqb_reg;
        slot_dist_next  = slot_dist_reg;
        slot_label_next = slot_label_reg;
        for (int j = 0; j < NEIGHBORS; j++) begin
            closer[j] = !slot_vld_reg[j] || (new_dist < slot_dist_reg[j]);
        end
        slot_vld_next[0] = 1'b1;
        if (closer[0]) begin
            slot_dist_next[0]  = new_dist;
            slot_label_next[0] = lab3_reg;
        end
        for (int j = 1; j < NEIGHBORS; j++) begin
            slot_vld_next[j] = slot_vld_reg[j] | slot_vld_reg[j-1];
            if (closer[j]) begin
                if (closer[j-1]) begin
                    slot_dist_next[j]  = slot_dist_reg[j-1];
                    slot_label_next[j] = slot_label_reg[j-1];
                end else begin
                    slot_dist_next[j]  = new_dist;
                    slot_label_next[j] = lab3_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg) begin
            slot_dist_reg  <= slot_dist_next;
            slot_label_reg <= slot_label_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else if (query_start) begin
            slot_vld_reg <= '0;
        end else if (v3_reg) begin
            slot_vld_reg <= slot_vld_next;
        end
    end

    // One Boyer-Moore step per cycle over the ranked labels.
    assign r_idx     = vote_r_reg[SW-1:0];
    assign cur_label = slot_label_reg[r_idx];
    assign vote_end  = (vote_r_reg == RW'(NEIGHBORS)) ? 1'b1 : !slot_vld_reg[r_idx];
    assign votes_step = (cur_label == cand_reg) ? (votes_reg + RW'(1))
                                                : (votes_reg - RW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_r_reg <= '0;
            votes_reg  <= '0;
        end else if (state_reg == ST_DRAIN) begin
            vote_r_reg <= RW'(1);
            votes_reg  <= RW'(1);
        end else if ((state_reg == ST_VOTE) && !vote_end) begin
            vote_r_reg <= vote_r_reg + RW'(1);
            votes_reg  <= (votes_step == '0) ? RW'(1) : votes_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DRAIN) begin
            cand_reg <= slot_label_reg[0];
        end else if ((state_reg == ST_VOTE) && !vote_end && (votes_step == '0)) begin
            cand_reg <= cur_label;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == last_idx_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!v0_reg && !v1_reg && !v2_reg && !v3_reg) begin
                    state_next = ST_VOTE;
                end
            end
            ST_VOTE: begin
                if (vote_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_label_reg <= cand_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_predicted_label = m_label_reg;

    // A load never leaves the controller busy.
    `KNN2F_ASSERT_NEXT(a_load_stays_idle, aclk, aresetn,
        s_accept && (s_command == CMD_LOAD), state_reg == ST_IDLE)
    // Distances only reach the sorted list while a query scans or drains.
    `KNN2F_ASSERT_IMP(a_insert_in_query, aclk, aresetn,
        v3_reg, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
    // Filled slots always form a prefix of the sorted list.
    `KNN2F_ASSERT_IMP(a_slot_prefix, aclk, aresetn,
        1'b1, (slot_vld_reg & (slot_vld_reg + NEIGHBORS'(1))) == '0)
    // The read address never passes the last entry in use.
    `KNN2F_ASSERT_IMP(a_scan_bound, aclk, aresetn,
        state_reg == ST_SCAN, cnt_reg <= last_idx_reg)
    // The surviving candidate always holds at least one vote.
    `KNN2F_ASSERT_IMP(a_votes_nonzero, aclk, aresetn,
        state_reg == ST_VOTE, (votes_reg != '0) && (slot_vld_reg[0] == 1'b1))

endmodule
